// ===== design/npp_pkg.sv =====
// Shared types and constants of the Newell polygon plane block.
package npp_pkg;

   // Field and datapath widths.
   localparam int COORD_W = 24;
   localparam int SUM_W = 56;
   localparam int NORM_W = 32;
   localparam int THR_W = 64;
   localparam int GAIN_W = 32;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 1'd1;

   // Configuration reset values.
   localparam logic [THR_W-1:0] THR_RESET = 64'd281474977;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd1000000;

   // Depth of the polygon queue between front and back end.
   localparam int QUEUE_DEPTH = 2;

   // One closed polygon handed from the front end to the back end.
   typedef struct packed {
      logic [2:0][SUM_W-1:0] sums;
      logic [2:0][COORD_W-1:0] first;
   } npp_poly_type;

endpackage

// ===== design/npp_front.sv =====
// Front end: accepts vertices and accumulates the three Newell sums.
module npp_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [npp_pkg::COORD_W-1:0] req_vertex_x,
   input  logic signed [npp_pkg::COORD_W-1:0] req_vertex_y,
   input  logic signed [npp_pkg::COORD_W-1:0] req_vertex_z,
   input  logic req_last_vertex,
   input  logic q_full,
   output logic q_push,
   output npp_pkg::npp_poly_type q_data
);

   localparam int CW = npp_pkg::COORD_W;
   localparam int SW = npp_pkg::SUM_W;
   localparam int PW = 2 * (CW + 1);

   logic [2:0][CW-1:0] first_ff, first_in;
   logic [2:0][CW-1:0] prev_ff, prev_in;
   logic [2:0][SW-1:0] sums_ff, sums_in;
   logic open_ff, open_in;
   logic closing_ff, closing_in;

   logic [2:0][CW-1:0] opb;
   logic signed [CW:0] add_t [3];
   logic signed [CW:0] dif_t [3];
   logic signed [PW-1:0] prod [3];
   logic [2:0][SW-1:0] sums_nx;
   logic accept;

   // Saturating add of a product onto a running sum.
   function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [PW-1:0] p);
      logic signed [SW:0] t;
      t = $signed({s[SW-1], s}) + $signed({{(SW+1-PW){p[PW-1]}}, p});
      if (t[SW] != t[SW-1]) begin
         sat_add = t[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         sat_add = t[SW-1:0];
      end
   endfunction

   assign accept = req_valid && req_ready;
   assign req_ready = !closing_ff;
   assign q_push = closing_ff && !q_full;

   // Second vertex of the pair: the new vertex, or the first one on closing.
   always_comb begin
      opb = {req_vertex_z, req_vertex_y, req_vertex_x};
      if (closing_ff) begin
         opb = first_ff;
      end
   end

   // Newell terms: x uses (z, y), y uses (x, z), z uses (y, x).
   always_comb begin
      add_t[0] = $signed({prev_ff[2][CW-1], prev_ff[2]}) + $signed({opb[2][CW-1], opb[2]});
      dif_t[0] = $signed({opb[1][CW-1], opb[1]}) - $signed({prev_ff[1][CW-1], prev_ff[1]});
      add_t[1] = $signed({prev_ff[0][CW-1], prev_ff[0]}) + $signed({opb[0][CW-1], opb[0]});
      dif_t[1] = $signed({opb[2][CW-1], opb[2]}) - $signed({prev_ff[2][CW-1], prev_ff[2]});
      add_t[2] = $signed({prev_ff[1][CW-1], prev_ff[1]}) + $signed({opb[1][CW-1], opb[1]});
      dif_t[2] = $signed({opb[0][CW-1], opb[0]}) - $signed({prev_ff[0][CW-1], prev_ff[0]});
      for (int k = 0; k < 3; k++) begin
         prod[k] = add_t[k] * dif_t[k];
         sums_nx[k] = sat_add(sums_ff[k], prod[k]);
      end
   end

   assign q_data.sums = sums_nx;
   assign q_data.first = first_ff;

   // Vertex bookkeeping and polygon state.
   always_comb begin
      first_in = first_ff;
      prev_in = prev_ff;
      sums_in = sums_ff;
      open_in = open_ff;
      closing_in = closing_ff;
      if (accept) begin
         prev_in = {req_vertex_z, req_vertex_y, req_vertex_x};
         closing_in = req_last_vertex;
         if (!open_ff) begin
            first_in = {req_vertex_z, req_vertex_y, req_vertex_x};
            sums_in = '0;
            open_in = 1'b1;
         end else begin
            sums_in = sums_nx;
         end
      end
      if (q_push) begin
         closing_in = 1'b0;
         open_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         prev_ff <= '0;
         sums_ff <= '0;
         open_ff <= 1'b0;
         closing_ff <= 1'b0;
      end else begin
         first_ff <= first_in;
         prev_ff <= prev_in;
         sums_ff <= sums_in;
         open_ff <= open_in;
         closing_ff <= closing_in;
      end
   end

`ifndef ASSERT_OFF
   // A closing beat always leaves the polygon open until it is queued.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_vertex) |=> (closing_ff && open_ff))
      else $error("closing vertex did not open the closing cycle");
`endif

endmodule

// ===== design/npp_queue.sv =====
// Short queue of closed polygons between the front and back end.
module npp_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  npp_pkg::npp_poly_type push_data,
   output logic full,
   input  logic pop,
   output logic pop_valid,
   output npp_pkg::npp_poly_type pop_data
);

   localparam int DEPTH = npp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   npp_pkg::npp_poly_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = entry_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("polygon queue overflow");
   assert property (@(posedge clock) disable iff (reset) pop |-> pop_valid)
      else $error("polygon queue underflow");
`endif

endmodule

// ===== design/npp_back.sv =====
// Back end: sequential normalization, degenerate scaling and plane offset.
module npp_back (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   input  npp_pkg::npp_poly_type q_data,
   output logic q_pop,
   input  logic [npp_pkg::THR_W-1:0] thr,
   input  logic [npp_pkg::GAIN_W-1:0] gain,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [npp_pkg::NORM_W-1:0] rsp_normal_x,
   output logic signed [npp_pkg::NORM_W-1:0] rsp_normal_y,
   output logic signed [npp_pkg::NORM_W-1:0] rsp_normal_z,
   output logic signed [npp_pkg::NORM_W-1:0] rsp_plane_offset,
   output logic rsp_degenerate
);

   localparam int SW = npp_pkg::SUM_W;
   localparam int CW = npp_pkg::COORD_W;
   localparam int NW = npp_pkg::NORM_W;
   localparam int AW = 58;
   localparam logic [NW-1:0] POS_MAX = {1'b0, {(NW-1){1'b1}}};
   localparam logic [NW-1:0] NEG_MIN = {1'b1, {(NW-1){1'b0}}};

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_SQ   = 10'b0000000010,
      ST_CHK  = 10'b0000000100,
      ST_DEG  = 10'b0000001000,
      ST_NORM = 10'b0000010000,
      ST_SQRT = 10'b0000100000,
      ST_DIV  = 10'b0001000000,
      ST_DOT  = 10'b0010000000,
      ST_OFF  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } npp_back_state_type;

   npp_back_state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic [2:0][SW-1:0] sum_ff, sum_in;
   logic [2:0][CW-1:0] pt_ff, pt_in;
   logic [2:0][63:0] mag_ff, mag_in;
   logic [127:0] mul_a_ff, mul_a_in;
   logic [63:0] mul_b_ff, mul_b_in;
   logic [127:0] prod_ff, prod_in;
   logic [63:0] root_ff, root_in;
   logic [66:0] rem_ff, rem_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [63:0] drem_ff, drem_in;
   logic [30:0] q_ff, q_in;
   logic [2:0][NW-1:0] nrm_ff, nrm_in;
   logic signed [55:0] pp_ff, pp_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [NW-1:0] off_ff, off_in;
   logic deg_ff, deg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0][NW-1:0] rsp_n_ff, rsp_n_in;
   logic [NW-1:0] rsp_off_ff, rsp_off_in;
   logic rsp_deg_ff, rsp_deg_in;

   logic [1:0] idx_nx;
   logic [127:0] mul_step;
   logic [63:0] g64;
   logic degen;
   logic [66:0] rem_sh, trial;
   logic sq_ge;
   logic div_ge;
   logic [63:0] dsub;
   logic [31:0] qn, qr, qsat;
   logic [NW-1:0] deg_val;
   logic signed [AW:0] tneg;
   logic signed [AW-26:0] tsh;
   logic load_rsp;

   // Magnitude of a signed Newell sum.
   function automatic logic [63:0] mag_of(input logic [SW-1:0] s);
      logic [SW-1:0] m;
      m = s[SW-1] ? (~s + 1'b1) : s;
      mag_of = {{(64-SW){1'b0}}, m};
   endfunction

   assign idx_nx = idx_ff + 1'b1;
   assign g64 = {26'd0, gain, 6'd0};
   assign mul_step = prod_ff + (mul_b_ff[0] ? mul_a_ff : 128'd0);
   assign degen = (prod_ff[127:64] == '0) && ((prod_ff[63:0] < thr) || (prod_ff[63:0] == '0));

   // Square root step: two radicand bits per cycle.
   assign rem_sh = {rem_ff[64:0], prod_ff[127:126]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign sq_ge = (rem_sh >= trial);

   // Division step and rounding to nearest.
   assign div_ge = (drem_ff >= root_ff);
   assign dsub = drem_ff - (div_ge ? root_ff : 64'd0);
   assign qn = {q_ff, div_ge};
   assign qr = qn + {31'd0, (dsub >= (root_ff - dsub))};
   assign qsat = (qr > {1'b0, {31{1'b1}}}) ? {1'b0, {31{1'b1}}} : qr;

   // Saturated degenerate component.
   always_comb begin
      if (!sum_ff[idx_ff][SW-1]) begin
         deg_val = (prod_ff > {96'd0, POS_MAX}) ? POS_MAX : prod_ff[NW-1:0];
      end else begin
         deg_val = (prod_ff > {96'd0, NEG_MIN}) ? NEG_MIN : (~prod_ff[NW-1:0] + 1'b1);
      end
   end

   // Plane offset: negate, add half, floor shift, saturate.
   assign tneg = -$signed({acc_ff[AW-1], acc_ff}) + $signed((AW+1)'(33554432));
   assign tsh = tneg[AW:26];

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   // Back-end sequencer.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      pt_in = pt_ff;
      mag_in = mag_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      prod_in = prod_ff;
      root_in = root_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      drem_in = drem_ff;
      q_in = q_ff;
      nrm_in = nrm_ff;
      pp_in = pp_ff;
      acc_in = acc_ff;
      off_in = off_ff;
      deg_in = deg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               sum_in = q_data.sums;
               pt_in = q_data.first;
               for (int k = 0; k < 3; k++) begin
                  mag_in[k] = mag_of(q_data.sums[k]);
               end
               idx_in = 2'd0;
               mul_a_in = {64'd0, mag_of(q_data.sums[0])};
               mul_b_in = mag_of(q_data.sums[0]);
               prod_in = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (mul_b_ff != '0) begin
               prod_in = mul_step;
               mul_a_in = {mul_a_ff[126:0], 1'b0};
               mul_b_in = {1'b0, mul_b_ff[63:1]};
            end else if (idx_ff == 2'd2) begin
               state_in = ST_CHK;
            end else begin
               idx_in = idx_nx;
               mul_a_in = {64'd0, mag_ff[idx_nx]};
               mul_b_in = mag_ff[idx_nx];
            end
         end
         ST_CHK: begin
            deg_in = degen;
            if (degen) begin
               idx_in = 2'd0;
               prod_in = '0;
               mul_a_in = {64'd0, mag_ff[0]};
               mul_b_in = g64;
               state_in = ST_DEG;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_DEG: begin
            if (mul_b_ff != '0) begin
               prod_in = mul_step;
               mul_a_in = {mul_a_ff[126:0], 1'b0};
               mul_b_in = {1'b0, mul_b_ff[63:1]};
            end else begin
               nrm_in[idx_ff] = deg_val;
               if (idx_ff == 2'd2) begin
                  idx_in = 2'd0;
                  acc_in = '0;
                  pp_in = '0;
                  state_in = ST_DOT;
               end else begin
                  idx_in = idx_nx;
                  prod_in = '0;
                  mul_a_in = {64'd0, mag_ff[idx_nx]};
                  mul_b_in = g64;
               end
            end
         end
         ST_NORM: begin
            if (prod_ff[127:124] == '0) begin
               prod_in = {prod_ff[125:0], 2'b00};
               for (int k = 0; k < 3; k++) begin
                  mag_in[k] = {mag_ff[k][62:0], 1'b0};
               end
            end else begin
               root_in = '0;
               rem_in = '0;
               cnt_in = 6'd63;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            prod_in = {prod_ff[125:0], 2'b00};
            rem_in = sq_ge ? (rem_sh - trial) : rem_sh;
            root_in = {root_ff[62:0], sq_ge};
            if (cnt_ff == '0) begin
               idx_in = 2'd0;
               drem_in = mag_ff[0];
               q_in = '0;
               cnt_in = 6'd30;
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIV: begin
            if (cnt_ff != '0) begin
               drem_in = {dsub[62:0], 1'b0};
               q_in = qn[30:0];
               cnt_in = cnt_ff - 1'b1;
            end else begin
               nrm_in[idx_ff] = sum_ff[idx_ff][SW-1] ? (~qsat + 1'b1) : qsat;
               if (idx_ff == 2'd2) begin
                  idx_in = 2'd0;
                  acc_in = '0;
                  pp_in = '0;
                  state_in = ST_DOT;
               end else begin
                  idx_in = idx_nx;
                  drem_in = mag_ff[idx_nx];
                  q_in = '0;
                  cnt_in = 6'd30;
               end
            end
         end
         ST_DOT: begin
            acc_in = acc_ff + AW'(pp_ff);
            if (idx_ff == 2'd3) begin
               state_in = ST_OFF;
            end else begin
               pp_in = $signed(nrm_ff[idx_ff]) * $signed(pt_ff[idx_ff]);
               idx_in = idx_nx;
            end
         end
         ST_OFF: begin
            if (tsh[AW-26] != tsh[AW-27]) begin
               off_in = tsh[AW-26] ? NEG_MIN : POS_MAX;
            end else begin
               off_in = tsh[NW-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_n_in = rsp_n_ff;
      rsp_off_in = rsp_off_ff;
      rsp_deg_in = rsp_deg_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_n_in = nrm_ff;
         rsp_off_in = off_ff;
         rsp_deg_in = deg_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_normal_x = rsp_n_ff[0];
   assign rsp_normal_y = rsp_n_ff[1];
   assign rsp_normal_z = rsp_n_ff[2];
   assign rsp_plane_offset = rsp_off_ff;
   assign rsp_degenerate = rsp_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      pt_ff <= pt_in;
      mag_ff <= mag_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      prod_ff <= prod_in;
      root_ff <= root_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      drem_ff <= drem_in;
      q_ff <= q_in;
      nrm_ff <= nrm_in;
      pp_ff <= pp_in;
      acc_ff <= acc_in;
      off_ff <= off_in;
      deg_ff <= deg_in;
      rsp_n_ff <= rsp_n_in;
      rsp_off_ff <= rsp_off_in;
      rsp_deg_ff <= rsp_deg_in;
   end

`ifndef ASSERT_OFF
   // The running division remainder never exceeds twice the root.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, drem_ff} <= {root_ff, 1'b0}))
      else $error("division remainder out of range");
   // A polygon is taken from the queue only by an idle back end.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_SQ))
      else $error("queue pop did not start the squaring pass");
`endif

endmodule

// ===== design/newell_polygon_plane.sv =====
// Top level of the Newell polygon plane block.
//
// Vertices enter on the req_ channel (valid/ready), one beat per vertex, in
// polygon order; req_last_vertex marks the beat that closes a polygon. Each
// closed polygon yields one beat on the rsp_ channel with the unit normal
// (Q1.30), the plane offset (Q27.4) and the degenerate flag.
// The front end takes one vertex per cycle when it is not stalled; after a
// closing vertex it adds the closing edge, and the polygon goes into a
// two-entry queue. The back end works on one polygon at a time through a
// shared shift-add multiplier, a two-bit-per-cycle square root and a
// bit-serial divider; its run time per polygon depends on the bit lengths
// of the Newell sums and of the gain. The front stalls in the closing cycle
// and when the queue is full. A stalled receiver holds the result in the
// output register; the back end waits, while the front keeps accepting
// vertices until the queue is full. Reset is synchronous and empties the
// queue, the output register and the open polygon; the configuration
// registers return to their reset values. Write csr_ only while the block
// is idle.
module newell_polygon_plane (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [23:0] req_vertex_x,
   input  logic signed [23:0] req_vertex_y,
   input  logic signed [23:0] req_vertex_z,
   input  logic req_last_vertex,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_normal_x,
   output logic signed [31:0] rsp_normal_y,
   output logic signed [31:0] rsp_normal_z,
   output logic signed [31:0] rsp_plane_offset,
   output logic rsp_degenerate,
   input  logic csr_write_enable,
   input  logic [npp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0] csr_write_data
);

   logic [npp_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [npp_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic q_push, q_full, q_pop, q_valid;
   npp_pkg::npp_poly_type q_wdata, q_rdata;

   // Configuration registers.
   always_comb begin
      thr_in = thr_ff;
      gain_in = gain_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            npp_pkg::CSR_THRESHOLD: thr_in = csr_write_data;
            npp_pkg::CSR_GAIN: gain_in = csr_write_data[npp_pkg::GAIN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= npp_pkg::THR_RESET;
         gain_ff <= npp_pkg::GAIN_RESET;
      end else begin
         thr_ff <= thr_in;
         gain_ff <= gain_in;
      end
   end

   npp_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_vertex_x(req_vertex_x),
      .req_vertex_y(req_vertex_y),
      .req_vertex_z(req_vertex_z),
      .req_last_vertex(req_last_vertex),
      .q_full(q_full),
      .q_push(q_push),
      .q_data(q_wdata)
   );

   npp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_wdata),
      .full(q_full),
      .pop(q_pop),
      .pop_valid(q_valid),
      .pop_data(q_rdata)
   );

   npp_back u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_data(q_rdata),
      .q_pop(q_pop),
      .thr(thr_ff),
      .gain(gain_ff),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z),
      .rsp_plane_offset(rsp_plane_offset),
      .rsp_degenerate(rsp_degenerate)
   );

endmodule

// ===== dv/npp_checker.sv =====
// Scoreboard of the Newell polygon plane block: predicts each plane and compares it.
`timescale 1ns / 1ps

module npp_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic signed [23:0] req_vertex_x,
   input  logic signed [23:0] req_vertex_y,
   input  logic signed [23:0] req_vertex_z,
   input  logic req_last_vertex,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic signed [31:0] rsp_normal_x,
   input  logic signed [31:0] rsp_normal_y,
   input  logic signed [31:0] rsp_normal_z,
   input  logic signed [31:0] rsp_plane_offset,
   input  logic rsp_degenerate,
   input  logic csr_write_enable,
   input  logic [npp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0] csr_write_data,
   output int fail_count,
   output int planes_pending,
   output int planes_checked,
   output int planes_degenerate
);

   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] offset;
      logic degen;
   } plane_type;

   // Shadow copy of the block's configuration and polygon state.
   logic [npp_pkg::THR_W-1:0] threshold;
   logic [npp_pkg::GAIN_W-1:0] gain;
   logic signed [npp_pkg::COORD_W-1:0] first_pt [3];
   logic signed [npp_pkg::COORD_W-1:0] prev_pt [3];
   logic signed [npp_pkg::SUM_W-1:0] newell_sum [3];
   logic polygon_open;
   plane_type expected_planes [$];

   function automatic logic signed [npp_pkg::SUM_W-1:0] sat_sum(
      input logic signed [127:0] v);
      if (v > (128'sd1 <<< (npp_pkg::SUM_W - 1)) - 1)
         return {1'b0, {(npp_pkg::SUM_W - 1){1'b1}}};
      if (v < -(128'sd1 <<< (npp_pkg::SUM_W - 1)))
         return {1'b1, {(npp_pkg::SUM_W - 1){1'b0}}};
      return v[npp_pkg::SUM_W-1:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
      if (v > 128'sd2147483647)
         return 32'sh7fffffff;
      if (v < -128'sd2147483648)
         return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [127:0] cross_term(input logic signed [127:0] p0, p1,
                                                      input logic signed [127:0] q0, q1);
      return (p0 + p1) * (q1 - q0);
   endfunction

   // Adds the Newell terms of the edge from a to b.
   task automatic add_edge(input logic signed [23:0] ax, ay, az, bx, by, bz);
      newell_sum[0] = sat_sum(newell_sum[0] + cross_term(az, bz, ay, by));
      newell_sum[1] = sat_sum(newell_sum[1] + cross_term(ax, bx, az, bz));
      newell_sum[2] = sat_sum(newell_sum[2] + cross_term(ay, by, ax, bx));
   endtask

   // Normalizes the sums (or scales them by the gain) and forms the plane offset.
   function automatic plane_type plane_of_sums();
      logic signed [127:0] sq_len, comp, scaled, mag, num, quo, rem, root, cand, dot;
      logic signed [127:0] norm [3];
      int shift_m;
      plane_type res;
      sq_len = 0;
      for (int i = 0; i < 3; i++) begin
         comp = newell_sum[i];
         sq_len = sq_len + comp * comp;
      end
      res.degen = (sq_len == 0) || (sq_len < $signed({64'd0, threshold}));
      if (res.degen) begin
         for (int i = 0; i < 3; i++) begin
            comp = newell_sum[i];
            norm[i] = sat32(comp * $signed({90'd0, gain, 6'd0}));
         end
      end else begin
         shift_m = 0;
         scaled = sq_len;
         while (scaled < (128'sd1 <<< 124)) begin
            scaled = scaled <<< 2;
            shift_m++;
         end
         root = 0;
         for (int b = 62; b >= 0; b--) begin
            cand = root | (128'sd1 <<< b);
            if (cand * cand <= scaled)
               root = cand;
         end
         for (int i = 0; i < 3; i++) begin
            comp = newell_sum[i];
            mag = comp < 0 ? -comp : comp;
            num = (mag <<< shift_m) <<< 30;
            quo = num / root;
            rem = num - quo * root;
            if (2 * rem >= root)
               quo = quo + 1;
            if (quo > 128'sh7fffffff)
               quo = 128'sh7fffffff;
            norm[i] = comp < 0 ? -quo : quo;
         end
      end
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         comp = first_pt[i];
         dot = dot + norm[i] * comp;
      end
      res.offset = sat32((-dot + (128'sd1 <<< 25)) >>> 26);
      res.nx = norm[0][31:0];
      res.ny = norm[1][31:0];
      res.nz = norm[2][31:0];
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      planes_pending = 0;
      planes_checked = 0;
      planes_degenerate = 0;
   end

   always @(posedge clock) begin
      plane_type exp_p;
      if (reset) begin
         threshold = npp_pkg::THR_RESET;
         gain = npp_pkg::GAIN_RESET;
         for (int i = 0; i < 3; i++) begin
            first_pt[i] = 0;
            prev_pt[i] = 0;
            newell_sum[i] = 0;
         end
         polygon_open = 1'b0;
         expected_planes.delete();
      end else begin
         // Register writes.
         if (csr_write_enable) begin
            if (csr_index == npp_pkg::CSR_THRESHOLD)
               threshold = csr_write_data;
            else if (csr_index == npp_pkg::CSR_GAIN)
               gain = csr_write_data[npp_pkg::GAIN_W-1:0];
         end

         // Result beats are checked against the oldest predicted plane.
         if (rsp_valid && rsp_ready) begin
            if (expected_planes.size() == 0) begin
               $display("%0t: result beat with no plane expected, actual %h %h %h %h %b",
                        $time, rsp_normal_x, rsp_normal_y, rsp_normal_z,
                        rsp_plane_offset, rsp_degenerate);
               fail_count++;
            end else begin
               exp_p = expected_planes.pop_front();
               check_field("normal_x", exp_p.nx, rsp_normal_x);
               check_field("normal_y", exp_p.ny, rsp_normal_y);
               check_field("normal_z", exp_p.nz, rsp_normal_z);
               check_field("plane_offset", exp_p.offset, rsp_plane_offset);
               check_field("degenerate", {31'd0, exp_p.degen}, {31'd0, rsp_degenerate});
               planes_checked++;
               if (exp_p.degen)
                  planes_degenerate++;
            end
         end

         // Vertex beats update the polygon; a closing vertex predicts one plane.
         if (req_valid && req_ready) begin
            if (!polygon_open) begin
               first_pt[0] = req_vertex_x;
               first_pt[1] = req_vertex_y;
               first_pt[2] = req_vertex_z;
               for (int i = 0; i < 3; i++)
                  newell_sum[i] = 0;
               polygon_open = 1'b1;
            end else begin
               add_edge(prev_pt[0], prev_pt[1], prev_pt[2],
                        req_vertex_x, req_vertex_y, req_vertex_z);
            end
            prev_pt[0] = req_vertex_x;
            prev_pt[1] = req_vertex_y;
            prev_pt[2] = req_vertex_z;
            if (req_last_vertex) begin
               add_edge(req_vertex_x, req_vertex_y, req_vertex_z,
                        first_pt[0], first_pt[1], first_pt[2]);
               expected_planes.push_back(plane_of_sums());
               polygon_open = 1'b0;
            end
         end
      end
      planes_pending <= expected_planes.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top of the Newell polygon plane block: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_top;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [23:0] req_vertex_x;
   logic signed [23:0] req_vertex_y;
   logic signed [23:0] req_vertex_z;
   logic req_last_vertex;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [31:0] rsp_normal_x;
   logic signed [31:0] rsp_normal_y;
   logic signed [31:0] rsp_normal_z;
   logic signed [31:0] rsp_plane_offset;
   logic rsp_degenerate;
   logic csr_write_enable;
   logic [npp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [63:0] csr_write_data;
   int fail_count;
   int planes_pending;
   int planes_checked;
   int planes_degenerate;
   int vertices_sent;
   logic steady;

   newell_polygon_plane u_top (.*);

   npp_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Random back-pressure on results, none during the steady stretch.
   always @(negedge clock)
      rsp_ready = steady ? 1'b1 : ($urandom_range(0, 99) >= 18);

   // Sends one vertex beat, sometimes with valid held low first.
   task automatic send_vertex(input logic signed [23:0] x, y, z, input logic last);
      @(negedge clock);
      if (!steady && $urandom_range(0, 99) < 18) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_vertex_x = x;
      req_vertex_y = y;
      req_vertex_z = z;
      req_last_vertex = last;
      do @(posedge clock); while (!req_ready);
      vertices_sent++;
   endtask

   // Waits until every predicted plane has come out, then lets the back end settle.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (planes_pending != 0) @(negedge clock);
      repeat (600) @(negedge clock);
   endtask

   task automatic write_csr(input logic [npp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic signed [23:0] rand_coord(input int shift);
      logic signed [23:0] v;
      v = 24'($urandom);
      return v >>> shift;
   endfunction

   // Random polygon: mostly small, sometimes one or two vertices, rarely long.
   // A share of polygons lie on a line, so their sums are zero.
   task automatic send_random_polygon();
      int count, shift, pick;
      logic signed [23:0] bx, by, bz, dx, dy, dz;
      pick = $urandom_range(0, 99);
      count = pick < 80 ? $urandom_range(3, 6) : (pick < 95 ? $urandom_range(1, 2)
                                                             : $urandom_range(7, 64));
      shift = $urandom_range(0, 20);
      if ($urandom_range(0, 99) < 6) begin
         bx = rand_coord(4);
         by = rand_coord(4);
         bz = rand_coord(4);
         dx = rand_coord(12);
         dy = rand_coord(12);
         dz = rand_coord(12);
         for (int k = 0; k < count; k++)
            send_vertex(24'(bx + k * dx), 24'(by + k * dy), 24'(bz + k * dz),
                        k == count - 1);
      end else begin
         for (int k = 0; k < count; k++)
            send_vertex(rand_coord(shift), rand_coord(shift), rand_coord(shift),
                        k == count - 1);
      end
   endtask

   task automatic random_phase(input int vertex_goal, input logic drain_midway);
      int half_goal;
      half_goal = vertices_sent + (vertex_goal - vertices_sent) / 2;
      while (vertices_sent < vertex_goal) begin
         if (drain_midway && vertices_sent >= half_goal) begin
            wait_drained();
            drain_midway = 1'b0;
         end
         steady = (vertices_sent % 400) >= 300;
         send_random_polygon();
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_vertex_x = '0;
      req_vertex_y = '0;
      req_vertex_z = '0;
      req_last_vertex = 1'b0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = npp_pkg::CSR_THRESHOLD;
      csr_write_data = '0;
      vertices_sent = 0;
      steady = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed polygons under the reset configuration.
      send_vertex(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1'b1);
      send_vertex(-24'sh800000, -24'sh800000, -24'sh800000, 1'b1);
      send_vertex(24'sh7fffff, -24'sh800000, 24'sh7fffff, 1'b0);
      send_vertex(-24'sh800000, 24'sh7fffff, 24'sh7fffff, 1'b0);
      send_vertex(24'sh7fffff, 24'sh7fffff, -24'sh800000, 1'b1);
      send_vertex(24'sh000000, 24'sh000000, 24'sh001000, 1'b0);
      send_vertex(24'sh001000, 24'sh000000, 24'sh001000, 1'b0);
      send_vertex(24'sh001000, 24'sh001000, 24'sh001000, 1'b0);
      send_vertex(24'sh000000, 24'sh001000, 24'sh001000, 1'b1);
      send_vertex(24'sh000010, 24'sh000020, 24'sh000030, 1'b0);
      send_vertex(24'sh000020, 24'sh000040, 24'sh000060, 1'b0);
      send_vertex(24'sh000030, 24'sh000060, 24'sh000090, 1'b1);
      send_vertex(24'sh000000, 24'sh000000, 24'sh000000, 1'b0);
      send_vertex(24'sh000001, 24'sh000000, 24'sh000000, 1'b0);
      send_vertex(24'sh000000, 24'sh000001, 24'sh000000, 1'b1);
      send_vertex(-24'sh800000, 24'sh7fffff, -24'sh800000, 1'b0);
      send_vertex(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1'b1);
      random_phase(400, 1'b0);
      wait_drained();

      // Zero threshold and zero gain: only zero-length normals are degenerate.
      write_csr(npp_pkg::CSR_THRESHOLD, 64'd0);
      write_csr(npp_pkg::CSR_GAIN, 64'd0);
      send_vertex(24'sh000100, 24'sh000200, 24'sh000300, 1'b1);
      random_phase(800, 1'b1);
      wait_drained();

      // Largest settings: every polygon with a squared length below 2^64 - 1 takes the saturating gain path.
      write_csr(npp_pkg::CSR_THRESHOLD, 64'hffffffffffffffff);
      write_csr(npp_pkg::CSR_GAIN, 64'h00000000ffffffff);
      random_phase(1150, 1'b0);
      wait_drained();

      // Random mid-range settings.
      write_csr(npp_pkg::CSR_THRESHOLD, {$urandom, $urandom} >> $urandom_range(8, 40));
      write_csr(npp_pkg::CSR_GAIN, {$urandom, $urandom});
      random_phase(1550, 1'b0);
      wait_drained();

      $display("Summary: %0d vertices sent, %0d planes checked (%0d degenerate),",
               vertices_sent, planes_checked, planes_degenerate);
      $display("Summary: covered under four register settings.");
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_top failed");
      $finish;
   end

endmodule
